>>> rtl/dtsp_pkg.sv
// ----------------------------------------------------------------------------
// dtsp_pkg
// Shared types and constants for the devicetree structure token parser.
// ----------------------------------------------------------------------------
package dtsp_pkg;

   // nesting limit: a begin-node that would reach it is a fault
   localparam int MAX_DEPTH     = 32;
   localparam int DEPTH_W       = $clog2(MAX_DEPTH);

   localparam int WORD_W        = 32;
   localparam int ROLE_W        = 4;
   localparam int NODE_DEPTH_W  = 6;
   localparam int FAULT_W       = 2;
   // ceil(len/4) reaches 2**30, so one bit more than len/4
   localparam int LEFT_W        = WORD_W - 1;

   // structure block tags
   localparam logic [WORD_W-1:0] TAG_BEGIN   = 32'h0000_0001;
   localparam logic [WORD_W-1:0] TAG_ENDNODE = 32'h0000_0002;
   localparam logic [WORD_W-1:0] TAG_PROP    = 32'h0000_0003;
   localparam logic [WORD_W-1:0] TAG_NOP     = 32'h0000_0004;
   localparam logic [WORD_W-1:0] TAG_END     = 32'h0000_0009;

   typedef enum logic [ROLE_W-1:0] {
      ROLE_BEGIN   = 4'd0,
      ROLE_NAME    = 4'd1,
      ROLE_ENDNODE = 4'd2,
      ROLE_PROP    = 4'd3,
      ROLE_LENGTH  = 4'd4,
      ROLE_NAMEOFF = 4'd5,
      ROLE_DATA    = 4'd6,
      ROLE_NOP     = 4'd7,
      ROLE_END     = 4'd8,
      ROLE_ERROR   = 4'd9,
      ROLE_IGNORED = 4'd10
   } role_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE        = 2'd0,
      FAULT_BAD_TAG     = 2'd1,
      FAULT_TOO_DEEP    = 2'd2,
      FAULT_END_AT_ZERO = 2'd3
   } fault_type;

   typedef struct packed {
      logic [WORD_W-1:0] blob_word;
      logic              restart;
   } item_type;

   typedef struct packed {
      role_type                word_role;
      logic [NODE_DEPTH_W-1:0] node_depth;
      logic                    last_name_word;
      logic                    empty_name;
      logic [WORD_W-1:0]       property_length;
      logic [WORD_W-1:0]       string_offset;
      logic                    last_data_word;
      fault_type               fault_code;
      logic                    finished;
   } result_type;

endpackage

>>> rtl/dtsp_channels.sv
// ----------------------------------------------------------------------------
// dtsp_req_if / dtsp_rsp_if
// Valid/ready channels carrying structure words in and tagged results out.
// ----------------------------------------------------------------------------
interface dtsp_req_if;
   logic                       valid;
   logic                       ready;
   logic [dtsp_pkg::WORD_W-1:0] blob_word;
   logic                       restart;

   modport source (output valid, output blob_word, output restart, input ready);
   modport sink   (input valid, input blob_word, input restart, output ready);
endinterface

interface dtsp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dtsp_pkg::ROLE_W-1:0]       word_role;
   logic [dtsp_pkg::NODE_DEPTH_W-1:0] node_depth;
   logic                             last_name_word;
   logic                             empty_name;
   logic [dtsp_pkg::WORD_W-1:0]       property_length;
   logic [dtsp_pkg::WORD_W-1:0]       string_offset;
   logic                             last_data_word;
   logic [dtsp_pkg::FAULT_W-1:0]      fault_code;
   logic                             finished;

   modport source (
      output valid, output word_role, output node_depth, output last_name_word,
      output empty_name, output property_length, output string_offset,
      output last_data_word, output fault_code, output finished, input ready
   );
   modport sink (
      input valid, input word_role, input node_depth, input last_name_word,
      input empty_name, input property_length, input string_offset,
      input last_data_word, input fault_code, input finished, output ready
   );
endinterface

>>> rtl/dtsp_in_reg.sv
// ----------------------------------------------------------------------------
// dtsp_in_reg
// Input register stage: captures one word per cycle unless a held word waits on step, drains on step.
// ----------------------------------------------------------------------------
module dtsp_in_reg (
   input  logic               clock,
   input  logic               reset,
   dtsp_req_if.sink           req_if,
   input  logic               step,
   output logic               item_valid,
   output dtsp_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   dtsp_pkg::item_type item_ff;
   logic               take;

   // free when empty or when the held word moves on this cycle
   assign req_if.ready = !valid_ff || step;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.blob_word <= req_if.blob_word;
         item_ff.restart   <= req_if.restart;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/dtsp_engine.sv
// ----------------------------------------------------------------------------
// dtsp_engine
// Parse state and result register: classifies one word per step.
// ----------------------------------------------------------------------------
module dtsp_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  dtsp_pkg::item_type   item,
   output dtsp_pkg::result_type result
);

   typedef enum logic [2:0] {
      MODE_TAG,
      MODE_NAME_FIRST,
      MODE_NAME_REST,
      MODE_LEN,
      MODE_NAMEOFF,
      MODE_DATA,
      MODE_DONE
   } mode_type;

   mode_type                        mode_ff,  mode_in,  mode_cur;
   logic [dtsp_pkg::DEPTH_W-1:0]    depth_ff, depth_in, depth_cur;
   logic [dtsp_pkg::LEFT_W-1:0]     left_ff,  left_in,  left_cur;
   logic [dtsp_pkg::WORD_W-1:0]     len_ff,   len_in,   len_cur;
   dtsp_pkg::fault_type             fault_ff, fault_in, fault_cur;
   dtsp_pkg::result_type            result_ff, result_in;

   logic [dtsp_pkg::WORD_W-1:0]     w;
   logic                            has_zero;
   logic [dtsp_pkg::LEFT_W-1:0]     left_dec;

   assign w        = item.blob_word;
   assign has_zero = (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
                     (w[15:8]  == 8'h00) || (w[7:0]   == 8'h00);

   always_comb begin
      // restart: behave as if from reset
      if (item.restart) begin
         mode_cur  = MODE_TAG;
         depth_cur = '0;
         left_cur  = '0;
         len_cur   = '0;
         fault_cur = dtsp_pkg::FAULT_NONE;
      end else begin
         mode_cur  = mode_ff;
         depth_cur = depth_ff;
         left_cur  = left_ff;
         len_cur   = len_ff;
         fault_cur = fault_ff;
      end

      mode_in  = mode_cur;
      depth_in = depth_cur;
      left_in  = left_cur;
      len_in   = len_cur;
      fault_in = fault_cur;
      left_dec = (left_cur != '0) ? left_cur - 1'b1 : left_cur;

      result_in                 = '0;
      result_in.word_role       = dtsp_pkg::ROLE_IGNORED;

      unique case (mode_cur)
         MODE_TAG: begin
            priority if (w == dtsp_pkg::TAG_BEGIN) begin
               if (depth_cur == dtsp_pkg::DEPTH_W'(dtsp_pkg::MAX_DEPTH - 1)) begin
                  fault_in            = dtsp_pkg::FAULT_TOO_DEEP;
                  mode_in             = MODE_DONE;
                  result_in.word_role = dtsp_pkg::ROLE_ERROR;
               end else begin
                  depth_in            = depth_cur + 1'b1;
                  mode_in             = MODE_NAME_FIRST;
                  result_in.word_role = dtsp_pkg::ROLE_BEGIN;
               end
            end else if (w == dtsp_pkg::TAG_ENDNODE) begin
               if (depth_cur == '0) begin
                  fault_in            = dtsp_pkg::FAULT_END_AT_ZERO;
                  mode_in             = MODE_DONE;
                  result_in.word_role = dtsp_pkg::ROLE_ERROR;
               end else begin
                  depth_in            = depth_cur - 1'b1;
                  result_in.word_role = dtsp_pkg::ROLE_ENDNODE;
               end
            end else if (w == dtsp_pkg::TAG_PROP) begin
               mode_in             = MODE_LEN;
               result_in.word_role = dtsp_pkg::ROLE_PROP;
            end else if (w == dtsp_pkg::TAG_NOP) begin
               result_in.word_role = dtsp_pkg::ROLE_NOP;
            end else if (w == dtsp_pkg::TAG_END) begin
               mode_in             = MODE_DONE;
               result_in.word_role = dtsp_pkg::ROLE_END;
            end else begin
               fault_in            = dtsp_pkg::FAULT_BAD_TAG;
               mode_in             = MODE_DONE;
               result_in.word_role = dtsp_pkg::ROLE_ERROR;
            end
         end
         MODE_NAME_FIRST, MODE_NAME_REST: begin
            result_in.word_role  = dtsp_pkg::ROLE_NAME;
            result_in.empty_name = (mode_cur == MODE_NAME_FIRST) && (w[31:24] == 8'h00);
            if (has_zero) begin
               result_in.last_name_word = 1'b1;
               mode_in                  = MODE_TAG;
            end else begin
               mode_in                  = MODE_NAME_REST;
            end
         end
         MODE_LEN: begin
            // word count is ceil(len/4)
            len_in                    = w;
            left_in                   = {1'b0, w[31:2]} +
                                        dtsp_pkg::LEFT_W'(w[1:0] != 2'b00);
            result_in.word_role       = dtsp_pkg::ROLE_LENGTH;
            result_in.property_length = w;
            mode_in                   = MODE_NAMEOFF;
         end
         MODE_NAMEOFF: begin
            result_in.word_role       = dtsp_pkg::ROLE_NAMEOFF;
            result_in.property_length = len_cur;
            result_in.string_offset   = w;
            mode_in                   = (left_cur == '0) ? MODE_TAG : MODE_DATA;
         end
         MODE_DATA: begin
            result_in.word_role       = dtsp_pkg::ROLE_DATA;
            result_in.property_length = len_cur;
            left_in                   = left_dec;
            if (left_dec == '0) begin
               result_in.last_data_word = 1'b1;
               mode_in                  = MODE_TAG;
            end
         end
         default: begin
            // done, or an unused code: stay stopped
            mode_in = MODE_DONE;
         end
      endcase

      result_in.node_depth = dtsp_pkg::NODE_DEPTH_W'(depth_in);
      result_in.fault_code = fault_in;
      result_in.finished   = (mode_in == MODE_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TAG;
         depth_ff <= '0;
         left_ff  <= '0;
         len_ff   <= '0;
         fault_ff <= dtsp_pkg::FAULT_NONE;
      end else if (step) begin
         mode_ff   <= mode_in;
         depth_ff  <= depth_in;
         left_ff   <= left_in;
         len_ff    <= len_in;
         fault_ff  <= fault_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/devicetree_struct_token_parser_top.sv
// ----------------------------------------------------------------------------
// devicetree_struct_token_parser_top
// Streaming role tagger for flattened devicetree structure-block words.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  - sink channel. Each transaction carries one big-endian 32-bit
//             structure word (first byte in bits 31:24) and a restart flag
//             that wipes the parse state before the word is taken as a tag.
//   rsp_if  - source channel. Exactly one result transaction per request:
//             word role, node depth after the word, name/data end flags,
//             property length, string offset, sticky fault code, finished.
// Timing:
//   A word lands in the input register when it is accepted, is classified
//   by the engine on a step and its result is held in the result register,
//   where rsp_if.valid offers it; a stalled result slot delays the step.
//   One word per cycle sustained while rsp_if.ready stays high; the only
//   loop is the small mode/depth/word-count update in the engine.
// Reset (synchronous, active high):
//   Both stages empty, mode back to expecting a tag, depth, count, held
//   length and fault cleared.
// Stall:
//   While rsp_if.ready is low the result holds; the input register takes
//   one more word if it is empty, then req_if.ready drops until the result moves.
// ----------------------------------------------------------------------------
module devicetree_struct_token_parser_top (
   input  logic       clock,
   input  logic       reset,
   dtsp_req_if.sink   req_if,
   dtsp_rsp_if.source rsp_if
);

   logic                 item_valid;   // input register holds a word
   dtsp_pkg::item_type   item;         // the held word
   dtsp_pkg::result_type result;       // engine result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 out_free;     // result register free this cycle
   logic                 step;         // classify the held word now

   // a result slot opens when empty or when the current result is taken
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign step     = item_valid && out_free;

   // stage 1: input register
   dtsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   // stage 2: parse state plus result payload
   dtsp_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .result (result)
   );

   // result valid: set on step, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.word_role       = result.word_role;
   assign rsp_if.node_depth      = result.node_depth;
   assign rsp_if.last_name_word  = result.last_name_word;
   assign rsp_if.empty_name      = result.empty_name;
   assign rsp_if.property_length = result.property_length;
   assign rsp_if.string_offset   = result.string_offset;
   assign rsp_if.last_data_word  = result.last_data_word;
   assign rsp_if.fault_code      = result.fault_code;
   assign rsp_if.finished        = result.finished;

endmodule

>>> rtl/dtsp_checker.sv
// ----------------------------------------------------------------------------
// dtsp_checker
// Port-level checks on the token parser, bound to the top level.
// ----------------------------------------------------------------------------
module dtsp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [dtsp_pkg::ROLE_W-1:0]        word_role,
   input logic                               last_name_word,
   input logic                               last_data_word,
   input logic [dtsp_pkg::FAULT_W-1:0]       fault_code,
   input logic                               finished
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // ignored words and faults only occur once parsing has stopped
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((word_role == dtsp_pkg::ROLE_IGNORED) ||
                    (fault_code != dtsp_pkg::FAULT_NONE)) |-> finished)
      else $error("ignored word or fault without finished");

   // end flags belong to their roles
   a_flag_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (last_data_word || last_name_word) |->
         ((last_data_word && word_role == dtsp_pkg::ROLE_DATA) ||
          (last_name_word && word_role == dtsp_pkg::ROLE_NAME)))
      else $error("end flag on wrong role");

endmodule

bind devicetree_struct_token_parser_top dtsp_checker u_dtsp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .word_role      (rsp_if.word_role),
   .last_name_word (rsp_if.last_name_word),
   .last_data_word (rsp_if.last_data_word),
   .fault_code     (rsp_if.fault_code),
   .finished       (rsp_if.finished)
);

>>> tb/sv/tb_devicetree_struct_token_parser_top.sv
// ----------------------------------------------------------------------------
// tb_devicetree_struct_token_parser_top
// Self-checking bench for the devicetree structure-block word tagger.
// Words go in over the request channel and each one is run through a
// local copy of the parse state. The tagged result that comes back on the
// response channel is compared field by field against that copy. Both
// channels idle at random. The run covers directed tokens, the three
// faults, the nesting limit, random well-formed trees and broken streams.
// ----------------------------------------------------------------------------
module tb_devicetree_struct_token_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   // generous watchdog bound for the whole run
   localparam int CYCLE_LIMIT = 200000;

   // parse modes of the local tagger
   typedef enum logic [2:0] {
      MODE_TAG,
      MODE_NAME_FIRST,
      MODE_NAME_REST,
      MODE_LEN,
      MODE_NAMEOFF,
      MODE_DATA,
      MODE_DONE
   } parse_mode_type;

   logic clock = 1'b0;
   logic reset;

   dtsp_req_if req_if ();
   dtsp_rsp_if rsp_if ();

   devicetree_struct_token_parser_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Local parse state, advanced once per accepted word
   // ---------------------------------------------------------------------
   parse_mode_type                  mode_q       = MODE_TAG;
   int unsigned                     depth_q      = 0;
   logic [dtsp_pkg::LEFT_W-1:0]     data_left_q  = '0;
   logic [dtsp_pkg::WORD_W-1:0]     prop_len_q   = '0;
   dtsp_pkg::fault_type             fault_q      = dtsp_pkg::FAULT_NONE;

   // tagged results still owed by the block, oldest first
   dtsp_pkg::result_type tagged_words[$];

   int                 error_count  = 0;
   int                 words_sent   = 0;
   int                 cycle_count  = 0;
   bit                 req_idle_on  = 1'b1;
   bit                 rsp_idle_on  = 1'b1;
   // restart flag for the next word sent; cleared once it is used
   bit                 restart_pending = 1'b0;

   // Tags one word and moves the local parse state along.
   function automatic dtsp_pkg::result_type tag_word(
      input logic [dtsp_pkg::WORD_W-1:0] w,
      input logic                        rst
   );
      dtsp_pkg::result_type r;
      r = '0;
      r.word_role = dtsp_pkg::ROLE_IGNORED;
      r.fault_code = dtsp_pkg::FAULT_NONE;
      if (rst) begin
         mode_q      = MODE_TAG;
         depth_q     = 0;
         data_left_q = '0;
         prop_len_q  = '0;
         fault_q     = dtsp_pkg::FAULT_NONE;
      end
      case (mode_q)
         MODE_TAG: begin
            if (w == dtsp_pkg::TAG_BEGIN) begin
               // a begin that would reach the limit stops parsing, depth kept
               if (depth_q + 1 >= dtsp_pkg::MAX_DEPTH) begin
                  fault_q     = dtsp_pkg::FAULT_TOO_DEEP;
                  mode_q      = MODE_DONE;
                  r.word_role = dtsp_pkg::ROLE_ERROR;
               end else begin
                  depth_q     = depth_q + 1;
                  r.word_role = dtsp_pkg::ROLE_BEGIN;
                  mode_q      = MODE_NAME_FIRST;
               end
            end else if (w == dtsp_pkg::TAG_ENDNODE) begin
               if (depth_q == 0) begin
                  fault_q     = dtsp_pkg::FAULT_END_AT_ZERO;
                  mode_q      = MODE_DONE;
                  r.word_role = dtsp_pkg::ROLE_ERROR;
               end else begin
                  depth_q     = depth_q - 1;
                  r.word_role = dtsp_pkg::ROLE_ENDNODE;
               end
            end else if (w == dtsp_pkg::TAG_PROP) begin
               r.word_role = dtsp_pkg::ROLE_PROP;
               mode_q      = MODE_LEN;
            end else if (w == dtsp_pkg::TAG_NOP) begin
               r.word_role = dtsp_pkg::ROLE_NOP;
            end else if (w == dtsp_pkg::TAG_END) begin
               r.word_role = dtsp_pkg::ROLE_END;
               mode_q      = MODE_DONE;
            end else begin
               fault_q     = dtsp_pkg::FAULT_BAD_TAG;
               mode_q      = MODE_DONE;
               r.word_role = dtsp_pkg::ROLE_ERROR;
            end
         end
         MODE_NAME_FIRST, MODE_NAME_REST: begin
            r.word_role = dtsp_pkg::ROLE_NAME;
            if (mode_q == MODE_NAME_FIRST && w[31:24] == 8'h00)
               r.empty_name = 1'b1;
            if (w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
                w[15:8] == 8'h00 || w[7:0] == 8'h00) begin
               r.last_name_word = 1'b1;
               mode_q = MODE_TAG;
            end else begin
               mode_q = MODE_NAME_REST;
            end
         end
         MODE_LEN: begin
            r.word_role = dtsp_pkg::ROLE_LENGTH;
            prop_len_q  = w;
            // ceil(len/4)
            data_left_q = dtsp_pkg::LEFT_W'(w[31:2]) +
                          dtsp_pkg::LEFT_W'(w[1:0] != 2'b00);
            r.property_length = prop_len_q;
            mode_q = MODE_NAMEOFF;
         end
         MODE_NAMEOFF: begin
            r.word_role       = dtsp_pkg::ROLE_NAMEOFF;
            r.property_length = prop_len_q;
            r.string_offset   = w;
            mode_q = (data_left_q == '0) ? MODE_TAG : MODE_DATA;
         end
         MODE_DATA: begin
            r.word_role       = dtsp_pkg::ROLE_DATA;
            r.property_length = prop_len_q;
            if (data_left_q != '0)
               data_left_q = data_left_q - 1'b1;
            if (data_left_q == '0) begin
               r.last_data_word = 1'b1;
               mode_q = MODE_TAG;
            end
         end
         default: begin
            mode_q      = MODE_DONE;
            r.word_role = dtsp_pkg::ROLE_IGNORED;
         end
      endcase
      r.node_depth = dtsp_pkg::NODE_DEPTH_W'(depth_q);
      r.fault_code = fault_q;
      r.finished   = (mode_q == MODE_DONE);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one word per call, random gap before it
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [dtsp_pkg::WORD_W-1:0] word);
      int   gap;
      logic rst;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      rst = restart_pending;
      restart_pending = 1'b0;
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.blob_word <= word;
      req_if.restart   <= rst;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      // transaction taken at this edge
      tagged_words.push_back(tag_word(word, rst));
      words_sent++;
   endtask

   // Name chunk: all bytes nonzero, or with a terminating zero byte.
   function automatic logic [dtsp_pkg::WORD_W-1:0] name_chunk(input bit closing);
      logic [dtsp_pkg::WORD_W-1:0] w;
      int                          pos;
      for (int i = 0; i < 4; i++)
         w[i*8 +: 8] = 8'($urandom_range(1, 255));
      if (closing) begin
         pos = $urandom_range(0, 3);
         w[pos*8 +: 8] = 8'h00;
         // sometimes zero-pad the rest of the word too
         if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < pos; i++)
               w[i*8 +: 8] = 8'h00;
      end
      return w;
   endfunction

   task automatic send_name(input bit root);
      int count;
      if (root) begin
         send_word({8'h00, 24'($urandom)});
      end else begin
         count = $urandom_range(1, 4);
         for (int i = 0; i < count - 1; i++)
            send_word(name_chunk(1'b0));
         send_word(name_chunk(1'b1));
      end
   endtask

   task automatic send_property(input int unsigned len);
      send_word(dtsp_pkg::TAG_PROP);
      send_word(len);
      send_word($urandom);
      for (int unsigned i = 0; i < (len + 3) / 4; i++)
         send_word($urandom);
   endtask

   // mostly short values, all four len%4 residues
   function automatic int unsigned prop_length();
      case ($urandom_range(0, 7))
         0, 1:    return $urandom_range(0, 3);
         7:       return $urandom_range(25, 64);
         default: return $urandom_range(4, 24);
      endcase
   endfunction

   // one of the five tags or an arbitrary word
   function automatic logic [dtsp_pkg::WORD_W-1:0] any_tag();
      case ($urandom_range(0, 5))
         0:       return dtsp_pkg::TAG_BEGIN;
         1:       return dtsp_pkg::TAG_ENDNODE;
         2:       return dtsp_pkg::TAG_PROP;
         3:       return dtsp_pkg::TAG_NOP;
         4:       return dtsp_pkg::TAG_END;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stall, then compare each result
   // ---------------------------------------------------------------------
   task automatic compare_field(input string field,
                                input logic [dtsp_pkg::WORD_W-1:0] want,
                                input logic [dtsp_pkg::WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         error_count++;
      end
   endtask

   task automatic check_tagged_word();
      dtsp_pkg::result_type want;
      if (tagged_words.size() == 0) begin
         $display("%0t: result with no word outstanding: expected none, actual role %0d",
                  $time, rsp_if.word_role);
         error_count++;
      end else begin
         want = tagged_words.pop_front();
         compare_field("word_role",       want.word_role,       rsp_if.word_role);
         compare_field("node_depth",      want.node_depth,      rsp_if.node_depth);
         compare_field("last_name_word",  want.last_name_word,  rsp_if.last_name_word);
         compare_field("empty_name",      want.empty_name,      rsp_if.empty_name);
         compare_field("property_length", want.property_length, rsp_if.property_length);
         compare_field("string_offset",   want.string_offset,   rsp_if.string_offset);
         compare_field("last_data_word",  want.last_data_word,  rsp_if.last_data_word);
         compare_field("fault_code",      want.fault_code,      rsp_if.fault_code);
         compare_field("finished",        want.finished,        rsp_if.finished);
      end
   endtask

   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 10) : 0;
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
         check_tagged_word();
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // every tag, empty and multi-word names, zero-length and padded data
   task automatic test_basic_tokens();
      restart_pending = 1'b1;
      send_word(dtsp_pkg::TAG_BEGIN);
      send_word(32'h0000_0000);       // root name, empty
      send_word(dtsp_pkg::TAG_PROP);
      send_word(32'h0000_0000);       // zero length: no data words follow
      send_word(32'hFFFF_FFFF);
      send_word(dtsp_pkg::TAG_PROP);
      send_word(32'h0000_0005);       // five bytes, two words
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      send_word(dtsp_pkg::TAG_NOP);
      send_word(dtsp_pkg::TAG_BEGIN);
      send_word(32'h6162_6364);       // no zero byte, name goes on
      send_word(32'h6566_6700);       // zero in the last byte
      send_word(dtsp_pkg::TAG_PROP);
      send_word(32'h0000_0004);
      send_word(32'h1234_5678);
      send_word(32'hDEAD_BEEF);
      send_word(dtsp_pkg::TAG_ENDNODE);
      send_word(dtsp_pkg::TAG_ENDNODE);
      send_word(dtsp_pkg::TAG_END);
      send_word(dtsp_pkg::TAG_BEGIN); // after the end tag: ignored
   endtask

   // bad tag and end-node at depth zero, both sticky until restart
   task automatic test_faults();
      restart_pending = 1'b1;
      send_word(dtsp_pkg::TAG_ENDNODE);
      send_word(32'hFFFF_FFFF);
      restart_pending = 1'b1;
      send_word(32'hFFFF_FFFF);
      restart_pending = 1'b1;
      send_word(dtsp_pkg::TAG_BEGIN);
      send_word(32'h4100_0000);
      send_word(32'h0000_0005);       // unknown tag at depth one
      restart_pending = 1'b1;
      send_word(dtsp_pkg::TAG_PROP);
      send_word(32'hFFFF_FFFF);       // largest length
      send_word(32'h0000_0000);
   endtask

   // nesting up to the limit, then one deeper; then down past zero
   task automatic test_depth_limit();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      restart_pending = 1'b1;
      for (int i = 0; i < dtsp_pkg::MAX_DEPTH - 1; i++) begin
         send_word(dtsp_pkg::TAG_BEGIN);
         send_name(i == 0);
      end
      send_word(dtsp_pkg::TAG_BEGIN);   // too deep
      send_word(dtsp_pkg::TAG_ENDNODE); // held fault, ignored
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      restart_pending = 1'b1;
      for (int i = 0; i < dtsp_pkg::MAX_DEPTH - 1; i++) begin
         send_word(dtsp_pkg::TAG_BEGIN);
         send_name(i == 0);
      end
      send_property(prop_length());
      for (int i = 0; i < dtsp_pkg::MAX_DEPTH - 1; i++)
         send_word(dtsp_pkg::TAG_ENDNODE);
      send_word(dtsp_pkg::TAG_ENDNODE); // end-node at zero
   endtask

   // well-formed trees with random shape and content
   task automatic test_random_trees();
      int depth;
      int steps;
      int trailing;
      while (words_sent < 600) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         restart_pending = 1'b1;
         send_word(dtsp_pkg::TAG_BEGIN);
         send_name(1'b1);
         depth = 1;
         steps = $urandom_range(4, 30);
         for (int s = 0; s < steps; s++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  if (depth < dtsp_pkg::MAX_DEPTH - 1) begin
                     send_word(dtsp_pkg::TAG_BEGIN);
                     send_name(1'b0);
                     depth++;
                  end
               end
               3, 4, 5: send_property(prop_length());
               6:       send_word(dtsp_pkg::TAG_NOP);
               default: begin
                  if (depth > 1) begin
                     send_word(dtsp_pkg::TAG_ENDNODE);
                     depth--;
                  end
               end
            endcase
         end
         while (depth > 0) begin
            send_word(dtsp_pkg::TAG_ENDNODE);
            depth--;
         end
         // usual end tag, or a fault to close the stream
         case ($urandom_range(0, 5))
            4:       send_word(dtsp_pkg::TAG_ENDNODE);
            5:       send_word($urandom);
            default: send_word(dtsp_pkg::TAG_END);
         endcase
         trailing = $urandom_range(0, 2);
         for (int t = 0; t < trailing; t++)
            send_word(any_tag());
      end
   endtask

   // noise, cut-off properties and names, restarts in mid stream
   task automatic test_broken_sequences();
      int count;
      while (words_sent < 750) begin
         if ($urandom_range(0, 7) == 0) begin
            req_idle_on = ($urandom_range(0, 2) != 0);
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         end
         case ($urandom_range(0, 4))
            0: begin
               restart_pending = ($urandom_range(0, 3) == 0);
               send_word($urandom);
            end
            1: begin
               // full-range length, cut short by the next restart
               restart_pending = 1'b1;
               send_word(dtsp_pkg::TAG_PROP);
               send_word($urandom);
               send_word($urandom);
               count = $urandom_range(0, 3);
               for (int i = 0; i < count; i++)
                  send_word($urandom);
            end
            2: begin
               // name that never terminates before a tag-like word
               restart_pending = 1'b1;
               send_word(dtsp_pkg::TAG_BEGIN);
               count = $urandom_range(1, 3);
               for (int i = 0; i < count; i++)
                  send_word(name_chunk(1'b0));
               restart_pending = 1'($urandom_range(0, 1));
               send_word(any_tag());
            end
            3: begin
               restart_pending = ($urandom_range(0, 7) == 0);
               send_word(any_tag());
            end
            default: begin
               restart_pending = 1'b1;
               send_property(prop_length());
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.blob_word = '0;
      req_if.restart   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_tokens();
      test_faults();
      test_depth_limit();
      test_random_trees();
      test_broken_sequences();

      @(negedge clock);
      req_if.valid <= 1'b0;

      // drain, then keep running to catch any stray result
      while (tagged_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
